### rtl/core/lzom_pkg.sv
// Shared types, constants and operation codes for the layer z-order manager.
package lzom_pkg;
   localparam int DefLayers = 256;
   localparam int CoordW    = 12;
   localparam int SizeW     = 11;
   localparam int RectW     = 13;

   localparam logic [2:0] FUNC_ALLOC   = 3'd0;
   localparam logic [2:0] FUNC_SIZE    = 3'd1;
   localparam logic [2:0] FUNC_HEIGHT  = 3'd2;
   localparam logic [2:0] FUNC_REFRESH = 3'd3;
   localparam logic [2:0] FUNC_SLIDE   = 3'd4;
   localparam logic [2:0] FUNC_FREE    = 3'd5;

   // request payload
   typedef struct packed {
      logic [10:0]        buf_height;
      logic [10:0]        buf_width;
      logic signed [11:0] y1;
      logic signed [11:0] x1;
      logic signed [11:0] y0;
      logic signed [11:0] x0;
      logic signed [8:0]  target_height;
      logic [7:0]         layer;
      logic [2:0]         func;
   } req_type;

   // result payload (without kind and last)
   typedef struct packed {
      logic [8:0]         shown_count;
      logic signed [12:0] rect_y1;
      logic signed [12:0] rect_x1;
      logic signed [12:0] rect_y0;
      logic signed [12:0] rect_x0;
      logic [7:0]         given_layer;
      logic               status;
   } rsp_type;
endpackage

### rtl/core/layer_z_order_manager.sv
// Top level of the layer z-order manager: sequencer over layer and stack memories.
//
// Usage: one operation item enters on req_ (tdata packs func, layer,
// target_height, x0, y0, x1, y1, buf_width, buf_height from bit 0 up).
// Results leave on rsp_: tuser is kind, tdata packs status, given_layer,
// rect_x0..rect_y1, shown_count; tlast marks the final result of an item.
// Operations are handled one at a time. Allocate scans the in-use
// table one entry a cycle. A height change shifts the stack list one
// entry at a time (read list, write list and read the moved layer,
// write back its height). These memory scans set the rate.
// After reset a clearing pass writes every entry of the layer table
// (free, hidden, zero geometry); no item is accepted during it.
// A stalled receiver holds the result in the output register; the block
// waits there and takes no new item until the last result leaves.
module layer_z_order_manager #(
   parameter int LAYERS = lzom_pkg::DefLayers
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // func, layer, target_height, x0, y0, x1, y1,
                                    // buf_width, buf_height, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status, given_layer, rect_x0, rect_y0, rect_x1,
                                    // rect_y1, shown_count, zero pad
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast
);
   import lzom_pkg::*;

   localparam int AW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   // signed height, holds -1..LAYERS and the raw 9-bit request
   localparam int HW = (AW + 2 > 10) ? AW + 2 : 10;

   localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2,
      S_DISP = 4'd3, S_SCAN = 4'd4, S_SHRD = 4'd5, S_SHWR = 4'd6,
      S_FIN = 4'd7, S_OUT = 4'd8, S_OUT2 = 4'd9, S_SCWT = 4'd10, S_SHHT = 4'd11;

   // layer table entry
   typedef struct packed {
      logic               used;
      logic signed [HW-1:0] hgt;
      logic signed [11:0] px;
      logic signed [11:0] py;
      logic [10:0]        sx;
      logic [10:0]        sy;
   } ent_type;

   ent_type         tab_mem [LAYERS];
   logic [AW-1:0]   stk_mem [LAYERS];

   logic [3:0]      state_ff, state_in;
   req_type         req_ff, req_in;
   ent_type         ent_ff, ent_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic signed [HW-1:0] top_ff, top_in;
   logic signed [HW-1:0] h_ff, h_in, tgt_ff, tgt_in;
   logic            dir_ff, dir_in;    // 1: shift entries up (raise from hidden or lower a shown layer)
   logic            lastsh_ff, lastsh_in;
   logic            free_ff, free_in;
   logic            ov_ff, ov_in, otl_ff, otl_in, okind_ff, okind_in;
   rsp_type         od_ff, od_in;

   // memory ports
   logic            tw_en;  logic [AW-1:0] tw_a; ent_type tw_d;
   logic [AW-1:0]   tr_a;   ent_type tr_q;
   logic            sw_en;  logic [AW-1:0] sw_a, sw_d;
   logic [AW-1:0]   sr_a, sr_q;

   // layer moved in the last shift write, used for its height update
   logic [AW-1:0]   sw_q_l, mv_ff;
   logic [AW-1:0]   lay_a;

   always_ff @(posedge clock) begin
      if (tw_en) tab_mem[tw_a] <= tw_d;
      tr_q <= tab_mem[tr_a];
   end
   always_ff @(posedge clock) begin
      if (sw_en) stk_mem[sw_a] <= sw_d;
      sr_q <= stk_mem[sr_a];
   end

   req_type rq;
   assign rq = req_type'(req_tdata[$bits(req_type)-1:0]);
   assign lay_a = AW'(req_ff.layer);
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tlast  = otl_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tdata  = {{(72 - $bits(rsp_type)){1'b0}}, od_ff};

   function automatic logic [AW-1:0] sl(input logic signed [HW-1:0] h);
      sl = h[AW-1:0];
   endfunction

   function automatic rsp_type mk(input logic signed [12:0] a, input logic signed [12:0] b,
                                  input logic signed [12:0] c, input logic signed [12:0] d,
                                  input logic signed [HW-1:0] t);
      logic signed [HW-1:0] n;
      n = t + 1'b1;
      mk = '{shown_count: 9'(unsigned'(n)), rect_y1: d, rect_x1: c, rect_y0: b,
             rect_x0: a, given_layer: '0, status: 1'b0};
   endfunction

   function automatic rsp_type lrect(input ent_type e, input logic signed [HW-1:0] t);
      lrect = mk(13'(e.px), 13'(e.py), 13'(e.px) + 13'(signed'({1'b0, e.sx})),
                 13'(e.py) + 13'(signed'({1'b0, e.sy})), t);
   endfunction

   logic signed [HW-1:0] clamp_hi, th_ext, th_cl;
   logic                 layer_ok;

   always_comb begin
      state_in = state_ff; req_in = req_ff; ent_in = ent_ff; cnt_in = cnt_ff;
      top_in = top_ff; h_in = h_ff; tgt_in = tgt_ff; dir_in = dir_ff;
      lastsh_in = lastsh_ff; free_in = free_ff;
      ov_in = ov_ff; otl_in = otl_ff; okind_in = okind_ff; od_in = od_ff;
      tw_en = 1'b0; tw_a = lay_a; tw_d = ent_ff;
      tr_a = lay_a;
      sw_en = 1'b0; sw_a = sl(h_ff); sw_d = sr_q; sr_a = sl(h_ff);
      layer_ok = (32'(req_ff.layer) < LAYERS);
      clamp_hi = (ent_ff.hgt >= 0) ? top_ff : top_ff + 1'b1;
      th_ext = HW'(req_ff.target_height);
      if (req_ff.func == FUNC_FREE) th_ext = '1;
      th_cl = th_ext;
      if (th_cl > clamp_hi) th_cl = clamp_hi;
      if (th_cl < -1) th_cl = '1;

      if (ov_ff && rsp_tready) ov_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            tw_en = 1'b1; tw_a = cnt_ff[AW-1:0];
            tw_d = '{used: 1'b0, hgt: '1, px: '0, py: '0, sx: '0, sy: '0};
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == LAYERS - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               req_in = rq; cnt_in = '0;
               state_in = (rq.func == FUNC_ALLOC) ? S_SCWT : S_READ;
            end
         end
         S_SCWT: begin
            tr_a = cnt_ff[AW-1:0];
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // tr_q holds entry cnt_ff
            if (!tr_q.used) begin
               ent_in = tr_q; ent_in.used = 1'b1; ent_in.hgt = '1;
               tw_en = 1'b1; tw_a = cnt_ff[AW-1:0]; tw_d = ent_in;
               od_in = mk('0, '0, '0, '0, top_ff);
               od_in.given_layer = 8'(cnt_ff);
               okind_in = 1'b0; otl_in = 1'b1; ov_in = 1'b1; state_in = S_OUT;
            end else if (32'(cnt_ff) == LAYERS - 1) begin
               od_in = mk('0, '0, '0, '0, top_ff); od_in.status = 1'b1;
               okind_in = 1'b0; otl_in = 1'b1; ov_in = 1'b1; state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               tr_a = AW'(cnt_ff + 1'b1);
            end
         end
         S_READ: state_in = S_DISP;
         S_DISP: begin
            ent_in = tr_q;
            okind_in = 1'b0; otl_in = 1'b1;
            od_in = mk('0, '0, '0, '0, top_ff);
            state_in = S_OUT; ov_in = 1'b1;
            if (!layer_ok || !tr_q.used || req_ff.func > FUNC_FREE) begin
               // plain acknowledgement
            end else begin
               case (req_ff.func)
                  FUNC_SIZE: begin
                     tw_en = 1'b1; tw_d = tr_q;
                     tw_d.sx = req_ff.buf_width; tw_d.sy = req_ff.buf_height;
                  end
                  FUNC_REFRESH: begin
                     if (tr_q.hgt >= 0) begin
                        okind_in = 1'b1;
                        od_in = mk(13'(tr_q.px) + 13'(req_ff.x0),
                                   13'(tr_q.py) + 13'(req_ff.y0),
                                   13'(tr_q.px) + 13'(req_ff.x1),
                                   13'(tr_q.py) + 13'(req_ff.y1), top_ff);
                     end
                  end
                  FUNC_SLIDE: begin
                     tw_en = 1'b1; tw_d = tr_q;
                     tw_d.px = req_ff.x0; tw_d.py = req_ff.y0;
                     ent_in = tw_d;
                     if (tr_q.hgt >= 0) begin
                        okind_in = 1'b1; otl_in = 1'b0;
                        od_in = lrect(tr_q, top_ff);
                        state_in = S_OUT2;
                     end
                  end
                  FUNC_HEIGHT, FUNC_FREE: begin
                     ov_in = 1'b0;
                     state_in = S_FIN;
                     free_in = (req_ff.func == FUNC_FREE);
                     lastsh_in = 1'b0;
                     state_in = S_SHRD; // overridden below: S_FIN or S_OUT
                     h_in = '0;
                     if (req_ff.func == FUNC_FREE && tr_q.hgt < 0) begin
                        tw_en = 1'b1; tw_d = tr_q; tw_d.used = 1'b0;
                        ov_in = 1'b1; state_in = S_OUT;
                     end else begin
                        state_in = S_FIN; // setup cycle
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FIN: begin
            // setup of the shift using clamped target
            tgt_in = th_cl;
            if (th_cl == ent_ff.hgt) begin
               okind_in = 1'b0; otl_in = 1'b1;
               od_in = mk('0, '0, '0, '0, top_ff);
               ov_in = 1'b1; state_in = S_OUT;
            end else begin
               ent_in.hgt = th_cl;
               if (ent_ff.hgt > th_cl && th_cl >= 0) begin
                  dir_in = 1'b1; h_in = ent_ff.hgt;  // move down: [h] <= [h-1]
                  lastsh_in = 1'b0;
               end else if (ent_ff.hgt > th_cl) begin
                  dir_in = 1'b0; h_in = ent_ff.hgt;  // hide: [h] <= [h+1] to top
                  lastsh_in = 1'b1;
               end else if (ent_ff.hgt >= 0) begin
                  dir_in = 1'b0; h_in = ent_ff.hgt; lastsh_in = 1'b0;
               end else begin
                  dir_in = 1'b1; h_in = top_ff + 1'b1; lastsh_in = 1'b1;
               end
               state_in = S_SHRD;
            end
         end
         S_SHRD: begin
            // h_ff: destination slot; done test
            if ((!dir_ff && !lastsh_ff && h_ff >= tgt_ff) ||
                (!dir_ff && lastsh_ff && h_ff >= top_ff) ||
                (dir_ff && h_ff <= tgt_ff)) begin
               // place layer or finish hide
               if (!(tgt_ff < 0)) begin
                  sw_en = 1'b1; sw_a = sl(tgt_ff); sw_d = lay_a;
               end
               if (tgt_ff < 0) top_in = top_ff - 1'b1;
               else if (ent_ff.hgt >= 0 && lastsh_ff && dir_ff) top_in = top_ff + 1'b1;
               tw_en = 1'b1; tw_d = ent_ff;
               if (free_ff) tw_d.used = 1'b0;
               okind_in = 1'b1; otl_in = 1'b1; ov_in = 1'b1;
               od_in = lrect(ent_ff, top_in);
               state_in = S_OUT;
            end else begin
               sr_a = dir_ff ? sl(h_ff - 1'b1) : sl(h_ff + 1'b1);
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            sw_en = 1'b1; sw_a = sl(h_ff); sw_d = sr_q;
            // update moved layer's height: read-modify-write via tab port
            tr_a = sr_q;
            h_in = dir_ff ? h_ff - 1'b1 : h_ff + 1'b1;
            state_in = S_SHHT;
         end
         S_SHHT: begin
            // tr_q is moved layer's entry; dest slot was h_ff -/+ 1 back
            tw_en = 1'b1; tw_a = sw_q_l; tw_d = tr_q;
            tw_d.hgt = dir_ff ? h_ff + 1'b1 : h_ff - 1'b1;
            state_in = S_SHRD;
         end
         S_OUT: if (!ov_ff || rsp_tready) begin
            if (ov_ff) ov_in = 1'b0;
            state_in = S_IDLE;
            if (ov_ff) state_in = S_IDLE;
            if (ov_ff && !rsp_tready) state_in = S_OUT;
         end
         S_OUT2: if (rsp_tready) begin
            okind_in = 1'b1; otl_in = 1'b1; ov_in = 1'b1;
            od_in = lrect(ent_ff, top_ff);
            state_in = S_OUT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) if (state_ff == S_SHWR) mv_ff <= sr_q;
   assign sw_q_l = mv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; cnt_ff <= '0; top_ff <= '1; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; top_ff <= top_in; ov_ff <= ov_in;
      end
      req_ff <= req_in; ent_ff <= ent_in; h_ff <= h_in; tgt_ff <= tgt_in;
      dir_ff <= dir_in; lastsh_ff <= lastsh_in; free_ff <= free_in;
      otl_ff <= otl_in; okind_ff <= okind_in; od_ff <= od_in;
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("accept while result pending");
   a_top_range: assert property (@(posedge clock) disable iff (reset)
      (top_ff >= -1) && (top_ff < LAYERS)) else $error("stack top out of range");
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_tvalid) else $error("result during clear");
`endif
endmodule
